// ----- rtl/core/pdqm_pkg.sv -----
// Package: types and constants shared by the queue manager modules.
package pdqm_pkg;
    localparam int NUM_DEST    = 16;
    localparam int QUEUE_DEPTH = 64;
    localparam int SLOT_W      = $clog2(NUM_DEST);
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_AW      = SLOT_W + PTR_W;
    localparam logic [31:0] RESET_MAX_BITS = 32'd1000000000;

    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_OVER    = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_TFULL   = 3'd3;
    localparam logic [2:0] ST_QFULL   = 3'd4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [47:0] dest_addr;
        logic [19:0] pkt_length_bits;
        logic [15:0] pkt_handle;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic        queue_exists;
        logic [15:0] head_handle;
        logic [19:0] head_length_bits;
        logic [6:0]  queue_count;
        logic [31:0] queue_bits;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture input item and look up slot
        logic execute;  // update queue state, build result
    } t_dp_cmd;
endpackage

// ----- rtl/core/pdqm_ctrl.sv -----
// Controller: sequences lookup and execute, owns the output handshake.
module pdqm_ctrl import pdqm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_dp_cmd o_cmd
);
    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_HOLD} t_state;
    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.execute = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (r_out_valid && !i_out_stall && !o_cmd.execute) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

// ----- rtl/core/pdqm_datapath.sv -----
// Datapath: address table, queue state, descriptor memory, result register.
module pdqm_datapath import pdqm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  t_in_item    i_item,
    input  logic [31:0] i_max_bits,
    output t_out_item   o_item
);
    logic [47:0]      r_addr  [NUM_DEST];
    logic             r_valid [NUM_DEST];
    logic [31:0]      r_bits  [NUM_DEST];
    logic [CNT_W-1:0] r_cnt   [NUM_DEST];
    logic [PTR_W-1:0] r_rptr  [NUM_DEST];
    logic [PTR_W-1:0] r_wptr  [NUM_DEST];
    logic [35:0]      r_mem   [NUM_DEST*QUEUE_DEPTH];
    logic [35:0]      r_rd;

    t_in_item         r_item;
    logic             r_hit, r_free_ok;
    logic [SLOT_W-1:0] r_slot, r_free;
    t_out_item        r_out;

    logic              m_hit, m_free_ok;
    logic [SLOT_W-1:0] m_slot, m_free;
    always_comb begin
        m_hit = 1'b0; m_slot = '0; m_free_ok = 1'b0; m_free = '0;
        for (int i = NUM_DEST - 1; i >= 0; i--) begin
            if (r_valid[i] && r_addr[i] == i_item.dest_addr) begin
                m_hit = 1'b1; m_slot = SLOT_W'(i);
            end
            if (!r_valid[i]) begin
                m_free_ok = 1'b1; m_free = SLOT_W'(i);
            end
        end
    end

    // Read head of the matched queue while the item is captured.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item    <= i_item;
            r_hit     <= m_hit;
            r_slot    <= m_slot;
            r_free_ok <= m_free_ok;
            r_free    <= m_free;
            r_rd      <= r_mem[{m_slot, r_rptr[m_slot]}];
        end
    end

    logic [SLOT_W-1:0] s;
    logic [32:0]       sum;
    logic              put, do_put, do_pop, nonempty;
    logic [31:0]       bits_n;
    logic [CNT_W-1:0]  cnt_n;
    t_out_item         res;
    always_comb begin
        put      = (r_item.cmd == CMD_PUT);
        s        = r_hit ? r_slot : r_free;
        sum      = {1'b0, r_bits[r_slot]} + 33'(r_item.pkt_length_bits);
        nonempty = r_hit && r_cnt[r_slot] != '0;
        do_put   = 1'b0;
        do_pop   = 1'b0;
        res      = '0;
        res.status = ST_OK;
        bits_n   = r_bits[s];
        cnt_n    = r_cnt[s];
        if (put) begin
            if (!r_hit) begin
                if (!r_free_ok) res.status = ST_TFULL;
                else begin
                    do_put = 1'b1;
                    bits_n = 32'(r_item.pkt_length_bits);
                    cnt_n  = CNT_W'(1);
                end
            end else if (sum > {1'b0, i_max_bits}) res.status = ST_OVER;
            else if (r_cnt[r_slot] >= CNT_W'(QUEUE_DEPTH)) res.status = ST_QFULL;
            else begin
                do_put = 1'b1;
                bits_n = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                cnt_n  = r_cnt[s] + CNT_W'(1);
            end
        end else if (!nonempty) res.status = ST_EMPTY;
        else begin
            res.head_handle      = r_rd[35:20];
            res.head_length_bits = r_rd[19:0];
            if (r_item.cmd == CMD_POP) begin
                do_pop = 1'b1;
                cnt_n  = r_cnt[s] - CNT_W'(1);
                bits_n = (r_bits[s] >= 32'(r_rd[19:0])) ?
                         r_bits[s] - 32'(r_rd[19:0]) : '0;
            end
        end
        res.queue_exists = r_hit || do_put;
        res.queue_count  = res.queue_exists ? 7'(cnt_n) : '0;
        res.queue_bits   = res.queue_exists ? bits_n : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_DEST; i++) begin
                r_valid[i] <= 1'b0; r_bits[i] <= '0; r_cnt[i] <= '0;
                r_rptr[i]  <= '0;   r_wptr[i] <= '0;
            end
        end else if (i_cmd.execute) begin
            if (do_put) begin
                if (!r_hit) begin
                    r_valid[s] <= 1'b1;
                    r_addr[s]  <= r_item.dest_addr;
                    r_rptr[s]  <= '0;
                    r_wptr[s]  <= PTR_W'(1);
                end else begin
                    r_wptr[s] <= (r_wptr[s] == PTR_W'(QUEUE_DEPTH - 1)) ?
                                 '0 : r_wptr[s] + PTR_W'(1);
                end
                r_bits[s] <= bits_n;
                r_cnt[s]  <= cnt_n;
            end
            if (do_pop) begin
                r_rptr[s] <= (r_rptr[s] == PTR_W'(QUEUE_DEPTH - 1)) ?
                             '0 : r_rptr[s] + PTR_W'(1);
                r_bits[s] <= bits_n;
                r_cnt[s]  <= cnt_n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && do_put)
            r_mem[{s, r_hit ? r_wptr[s] : PTR_W'(0)}] <=
                {r_item.pkt_handle, r_item.pkt_length_bits};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) r_out <= res;
    end

    assign o_item = r_out;
endmodule

// ----- rtl/core/per_destination_queue_manager_top.sv -----
// Top level: per-destination queue manager with bit accounting.
// Flow: the item is captured at the accepting edge, with slot lookup and descriptor read;
// the update and result register follow in the execute step, held off while a result stalls.
// No new item is accepted until the execute step is done; the memory is written there.
// Reset: slot table, counts, pointers and totals clear; limit returns to 1e9.
// Descriptor memory is not cleared; unwritten entries are never used in a result.
module per_destination_queue_manager_top import pdqm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data
);
    logic [31:0] r_max_bits;
    t_dp_cmd     cmd;

    // Hold the admission limit; the user must write it only while idle, the block does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_max_bits <= RESET_MAX_BITS;
        else if (i_cfg_we) r_max_bits <= i_cfg_data;
    end

    pdqm_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall,
        .o_out_valid, .i_out_stall, .o_cmd(cmd)
    );

    pdqm_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_item(i_in_item),
        .i_max_bits(r_max_bits), .o_item(o_out_item)
    );

    // A result waiting under stall must not change.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_item))
        else $error("result changed under stall");
    // Accepting an item blocks the next cycle's accept.
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second item accepted during execute");
    // Status stays within the defined codes.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.status <= ST_QFULL))
        else $error("bad status");
endmodule

// ----- tb/per_destination_queue_manager_top_tb.sv -----
// Testbench for the per-destination queue manager: predicted results checked against the block.
`timescale 1ns / 1ps

import pdqm_pkg::*;

// Queue manager predictor and the results it expects, oldest first.
class pdqm_scoreboard;
    logic [31:0] limit_bits;
    logic [47:0] addr_tab [NUM_DEST];
    bit          used [NUM_DEST];
    logic [31:0] total_bits [NUM_DEST];
    int          pkt_cnt [NUM_DEST];
    int          rd_ptr [NUM_DEST];
    int          wr_ptr [NUM_DEST];
    logic [15:0] st_handle [NUM_DEST*QUEUE_DEPTH];
    logic [19:0] st_len [NUM_DEST*QUEUE_DEPTH];
    t_out_item   pending [$];
    int          errors;
    int          checked;
    int          status_seen [8];

    function new();
        limit_bits = RESET_MAX_BITS;
        for (int i = 0; i < NUM_DEST; i++) begin
            used[i] = 0; total_bits[i] = 0; pkt_cnt[i] = 0;
            rd_ptr[i] = 0; wr_ptr[i] = 0; addr_tab[i] = '0;
        end
        errors = 0;
        checked = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int lookup(logic [47:0] a);
        for (int i = 0; i < NUM_DEST; i++)
            if (used[i] && addr_tab[i] == a) return i;
        return -1;
    endfunction

    function void note_item(t_in_item it);
        t_out_item r;
        int s;
        int idx;
        bit ok;
        logic [32:0] sum;
        r = '0;
        s = lookup(it.dest_addr);
        if (it.cmd == CMD_PUT) begin
            ok = 1;
            if (s < 0) begin
                for (int i = 0; i < NUM_DEST; i++)
                    if (!used[i] && s < 0) s = i;
                if (s < 0) begin
                    r.status = ST_TFULL;
                    ok = 0;
                end else begin
                    used[s] = 1; addr_tab[s] = it.dest_addr; total_bits[s] = 0;
                    pkt_cnt[s] = 0; rd_ptr[s] = 0; wr_ptr[s] = 0;
                end
            end else if ({1'b0, total_bits[s]} + 33'(it.pkt_length_bits) > {1'b0, limit_bits})
            begin
                r.status = ST_OVER;
                ok = 0;
            end else if (pkt_cnt[s] >= QUEUE_DEPTH) begin
                r.status = ST_QFULL;
                ok = 0;
            end
            if (ok) begin
                idx = s * QUEUE_DEPTH + wr_ptr[s];
                st_handle[idx] = it.pkt_handle;
                st_len[idx] = it.pkt_length_bits;
                wr_ptr[s] = (wr_ptr[s] + 1) % QUEUE_DEPTH;
                pkt_cnt[s]++;
                sum = {1'b0, total_bits[s]} + 33'(it.pkt_length_bits);
                total_bits[s] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end
        end else if (s < 0 || pkt_cnt[s] == 0) begin
            r.status = ST_EMPTY;
        end else begin
            idx = s * QUEUE_DEPTH + rd_ptr[s];
            r.head_handle = st_handle[idx];
            r.head_length_bits = st_len[idx];
            // any command other than pop reads the head without removing it
            if (it.cmd == CMD_POP) begin
                rd_ptr[s] = (rd_ptr[s] + 1) % QUEUE_DEPTH;
                pkt_cnt[s]--;
                total_bits[s] = total_bits[s] >= 32'(st_len[idx]) ?
                                total_bits[s] - 32'(st_len[idx]) : '0;
            end
        end
        if (s >= 0) begin
            r.queue_exists = 1;
            r.queue_count = 7'(pkt_cnt[s]);
            r.queue_bits = total_bits[s];
        end
        pending.push_back(r);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch on result %0d: %s got %0h want %0h", checked, what, got, want);
        errors++;
    endtask

    task check_result(t_out_item got);
        t_out_item w;
        if (pending.size() == 0) begin
            report("unexpected result", 64'(got.status), 64'(0));
            return;
        end
        w = pending.pop_front();
        status_seen[w.status]++;
        if (got.status !== w.status) report("status", 64'(got.status), 64'(w.status));
        if (got.queue_exists !== w.queue_exists)
            report("queue_exists", 64'(got.queue_exists), 64'(w.queue_exists));
        if (got.head_handle !== w.head_handle)
            report("head_handle", 64'(got.head_handle), 64'(w.head_handle));
        if (got.head_length_bits !== w.head_length_bits)
            report("head_length_bits", 64'(got.head_length_bits), 64'(w.head_length_bits));
        if (got.queue_count !== w.queue_count)
            report("queue_count", 64'(got.queue_count), 64'(w.queue_count));
        if (got.queue_bits !== w.queue_bits)
            report("queue_bits", 64'(got.queue_bits), 64'(w.queue_bits));
        checked++;
    endtask
endclass

module per_destination_queue_manager_top_tb;
    localparam int CYCLE_LIMIT = 400000;

    logic      i_clk = 0;
    logic      i_rst_n = 0;
    logic      i_in_valid = 0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 0;
    t_out_item o_out_item;
    logic      i_cfg_we = 0;
    logic [31:0] i_cfg_data = '0;

    pdqm_scoreboard sb;
    int  cycles = 0;
    bit  hold_sink = 0;     // set while the receiver holds off for the long stretch
    bit  gaps_on = 1;       // cleared for stretches with no idling
    int  sent = 0;
    logic [47:0] addr_pool [24];

    per_destination_queue_manager_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_item(o_out_item),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Watchdog: end the run if the block stops making progress.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[per_destination_queue_manager_top] ERROR");
            $finish;
        end
    end

    // Check every result at the edge where it is accepted.
    always @(posedge i_clk)
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_item);

    // Receiver: draw random stall stretches, or hold off entirely while asked.
    initial begin
        int w;
        forever begin
            @(negedge i_clk);
            if (hold_sink) begin
                i_out_stall <= 1;
            end else begin
                w = gaps_on ? $urandom_range(0, 16) : 0;
                if (w > 0 && $urandom_range(0, 3) == 0) begin
                    i_out_stall <= 1;
                    repeat (w) @(negedge i_clk);
                end
                i_out_stall <= 0;
            end
        end
    end

    // Offer one item, hold it until accepted, then sometimes drop valid for a random gap.
    task send_item(t_in_item it);
        int w;
        i_in_item <= it;
        i_in_valid <= 1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_item(it);
        sent++;
        @(negedge i_clk);
        w = gaps_on ? $urandom_range(0, 16) : 0;
        if (w > 0 && $urandom_range(0, 2) == 0) begin
            i_in_valid <= 0;
            repeat (w) @(negedge i_clk);
        end
    endtask

    task send(logic [1:0] c, logic [47:0] a, logic [19:0] l, logic [15:0] h);
        t_in_item it;
        it.cmd = c; it.dest_addr = a; it.pkt_length_bits = l; it.pkt_handle = h;
        send_item(it);
    endtask

    // Drain outstanding results, then write the limit while the block is idle.
    task set_limit(logic [31:0] v);
        @(negedge i_clk);
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_data <= v;
        sb.limit_bits = v;
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    function logic [47:0] rand_addr();
        return 48'({$urandom(), $urandom()});
    endfunction

    // Mostly puts and pops to a pool of addresses; some queries, unused commands and stray addresses.
    task random_items(int n, int pool_n, int max_len);
        int k;
        logic [1:0] c;
        logic [47:0] a;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            c = k < 50 ? CMD_PUT : (k < 85 ? CMD_POP : (k < 95 ? CMD_QUERY : CMD_SPARE));
            a = $urandom_range(0, 19) == 0 ? rand_addr() : addr_pool[$urandom_range(0, pool_n-1)];
            send(c, a, 20'($urandom_range(0, max_len)), 16'($urandom()));
        end
    endtask

    initial begin
        sb = new();
        for (int i = 0; i < 24; i++) addr_pool[i] = rand_addr();
        addr_pool[0] = '0;
        addr_pool[1] = 48'hFFFF_FFFF_FFFF;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: empty pops, limit edges, new queue above the limit, extremes, unused command.
        send(CMD_POP, addr_pool[0], 0, 0);
        send(CMD_QUERY, addr_pool[1], 0, 0);
        send(CMD_PUT, addr_pool[0], 20'hFFFFF, 16'hFFFF);
        send(CMD_PUT, addr_pool[1], 0, 0);
        send(CMD_SPARE, addr_pool[0], 0, 0);
        send(CMD_QUERY, addr_pool[1], 0, 0);
        send(CMD_POP, addr_pool[0], 0, 0);
        send(CMD_POP, addr_pool[0], 0, 0);
        set_limit(32'd100);
        send(CMD_PUT, addr_pool[1], 60, 16'h1234);
        send(CMD_PUT, addr_pool[1], 41, 16'h5678);   // over the limit
        send(CMD_PUT, addr_pool[1], 40, 16'h9ABC);   // exactly at the limit
        send(CMD_PUT, addr_pool[2], 20'hFFFFF, 1);   // new queue above the limit
        send(CMD_POP, addr_pool[1], 0, 0);
        set_limit(32'd0);
        send(CMD_PUT, addr_pool[1], 0, 16'hAAAA);
        send(CMD_PUT, addr_pool[1], 1, 16'h5555);
        set_limit(32'hFFFF_FFFF);
        // Fill one queue past its depth.
        for (int i = 0; i < QUEUE_DEPTH + 2; i++)
            send(CMD_PUT, addr_pool[3], 20'($urandom()), 16'(i));
        // Fill the table, then try addresses beyond it.
        for (int i = 4; i < 18; i++) send(CMD_PUT, addr_pool[i], 5, 16'(i));
        send(CMD_PUT, addr_pool[20], 5, 0);
        send(CMD_POP, addr_pool[20], 0, 0);

        // Long hold-off by the receiver while the sender keeps offering.
        fork
            begin
                hold_sink = 1;
                repeat (300) @(negedge i_clk);
                hold_sink = 0;
            end
            random_items(40, 18, 20'hFFFFF);
        join

        gaps_on = 0;
        random_items(200, 18, 20'hFFFFF);
        gaps_on = 1;
        random_items(300, 18, 20'hFFFFF);
        set_limit(32'd2000000);
        random_items(300, 18, 20'hFFFFF);
        set_limit(32'd5000);
        random_items(300, 18, 20'h3FF);
        set_limit(RESET_MAX_BITS);
        random_items(100, 18, 20'hFFFFF);

        @(negedge i_clk);
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);

        $display("sent %0d items, checked %0d results", sent, sb.checked);
        $display("status ok %0d, over %0d, empty %0d, table full %0d, queue full %0d",
                 sb.status_seen[ST_OK], sb.status_seen[ST_OVER], sb.status_seen[ST_EMPTY],
                 sb.status_seen[ST_TFULL], sb.status_seen[ST_QFULL]);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[per_destination_queue_manager_top] OK");
        else
            $display("[per_destination_queue_manager_top] ERROR");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/core/pdqm_pkg.sv
rtl/core/pdqm_ctrl.sv
rtl/core/pdqm_datapath.sv
rtl/core/per_destination_queue_manager_top.sv
tb/per_destination_queue_manager_top_tb.sv
